/* rtl/radix_digit_converter_assert.svh */
// Assertion macros for the radix digit converter checker.
// Used by rdc_checker.sv; no other dependencies.
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rdc_pkg.sv */
// Shared constants, types and helpers for the radix digit converter.
// No dependencies; imported by every module of the block.
package rdc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int VALUE_IN_W  = 32;
    localparam int RADIX_W     = 4;
    localparam int DIGIT_W     = 4;
    localparam int STEP_BITS   = 8;
    localparam int CHUNKS      = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int WORK_W      = CHUNKS * STEP_BITS;
    localparam int CHUNK_CNT_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int STACK_DEPTH = VALUE_WIDTH;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    typedef struct packed {
        logic load;
        logic step;
        logic pop;
    } t_dp_cmd;

    typedef struct packed {
        logic digit_end;
        logic quo_zero;
        logic last;
    } t_dp_sts;

    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] b;
        b = r;
        if (r < RADIX_MIN) begin
            b = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            b = RADIX_MAX;
        end
        return b;
    endfunction

endpackage

/* rtl/rdc_ctrl.sv */
// Controller state machine for the radix digit converter.
// Depends on rdc_pkg; drives rdc_dp through t_dp_cmd and reads t_dp_sts.
module rdc_ctrl
    import rdc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
                if (start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.digit_end && i_sts.quo_zero) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.pop = 1'b1;
                if (i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

/* rtl/rdc_dp.sv */
// Datapath for the radix digit converter: radix register, chunked divider,
// digit stack and output register. Depends on rdc_pkg.
module rdc_dp
    import rdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [RADIX_W-1:0]    i_cfg_wdata,
    input  logic [VALUE_IN_W-1:0] i_value,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_valid,
    output logic [DIGIT_W-1:0]    o_digit,
    output logic                  o_last_digit
);

    logic [RADIX_W-1:0]     r_radix;
    logic [RADIX_W-1:0]     base;
    logic [WORK_W-1:0]      r_work;
    logic [RADIX_W-1:0]     r_rem;
    logic [CHUNK_CNT_W-1:0] r_chunk;
    logic [SP_W-1:0]        r_sp;
    logic [SP_W-1:0]        sp_m1;
    logic [DIGIT_W-1:0]     r_stack [STACK_DEPTH];
    logic                   r_valid;
    logic [DIGIT_W-1:0]     r_digit;
    logic                   r_last;

    logic [WORK_W-1:0]      load_val;
    logic [STEP_BITS-1:0]   top;
    logic [STEP_BITS-1:0]   qbits;
    logic [RADIX_W:0]       acc;
    logic [RADIX_W-1:0]     n_rem;
    logic [WORK_W-1:0]      n_work;
    logic                   chunk_last;
    logic                   digit_end;

    assign base  = eff_radix(r_radix);
    assign sp_m1 = r_sp - SP_W'(1);

    always_comb begin
        load_val = '0;
        for (int i = 0; i < VALUE_WIDTH && i < VALUE_IN_W; i++) begin
            load_val[i] = i_value[i];
        end
    end

    always_comb begin
        top   = r_work[WORK_W-1 -: STEP_BITS];
        n_rem = r_rem;
        qbits = '0;
        acc   = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            acc = {n_rem, top[i]};
            if (acc >= {1'b0, base}) begin
                qbits[i] = 1'b1;
                acc      = acc - {1'b0, base};
            end
            n_rem = acc[RADIX_W-1:0];
        end
        n_work = (r_work << STEP_BITS) | WORK_W'(qbits);
    end

    assign chunk_last = (r_chunk == CHUNK_CNT_W'(CHUNKS - 1));
    assign digit_end  = i_cmd.step && chunk_last;

    assign o_sts.digit_end = digit_end;
    assign o_sts.quo_zero  = (n_work == '0);
    assign o_sts.last      = (r_sp == SP_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
            r_sp    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.pop;
            if (i_cmd.load) begin
                r_chunk <= '0;
                r_sp    <= '0;
            end else if (i_cmd.step) begin
                r_chunk <= chunk_last ? '0 : r_chunk + CHUNK_CNT_W'(1);
                if (chunk_last) begin
                    r_sp <= r_sp + SP_W'(1);
                end
            end else if (i_cmd.pop) begin
                r_sp <= sp_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work <= load_val;
            r_rem  <= '0;
        end else if (i_cmd.step) begin
            r_work <= n_work;
            r_rem  <= chunk_last ? '0 : n_rem;
        end
        if (digit_end) begin
            r_stack[r_sp[ADDR_W-1:0]] <= n_rem;
        end
        if (i_cmd.pop) begin
            r_digit <= r_stack[sp_m1[ADDR_W-1:0]];
            r_last  <= (r_sp == SP_W'(1));
        end
    end

    assign o_valid      = r_valid;
    assign o_digit      = r_digit;
    assign o_last_digit = r_last;

endmodule

/* rtl/radix_digit_converter.sv */
// Radix digit converter: one value in, its digits out most significant first.
// Each digit takes one pass of long division over the work register, 8 bits per
// cycle, then the digits are emitted one per cycle from the digit stack.
// A new value is taken only in idle, once the last digit has been popped.
// Synchronous active-low reset; radix returns to 10. Results cannot be stalled.
module radix_digit_converter
    import rdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [RADIX_W-1:0]    i_cfg_wdata,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_IN_W-1:0] i_value,
    output logic                  o_valid,
    output logic [DIGIT_W-1:0]    o_digit,
    output logic                  o_last_digit
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    rdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    rdc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_value      (i_value),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_digit      (o_digit),
        .o_last_digit (o_last_digit)
    );

endmodule

/* rtl/rdc_checker.sv */
// Port-level checker for radix_digit_converter, bound to the top level.
// Depends on rdc_pkg and radix_digit_converter_assert.svh.
`include "radix_digit_converter_assert.svh"

module rdc_checker
    import rdc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic [DIGIT_W-1:0]    o_digit,
    input logic                  o_last_digit
);

    `RDC_ASSERT_NXT(a_run_unbroken, i_clk, i_rst_n, o_valid && !o_last_digit, o_valid, "digit run broken before last digit")
    `RDC_ASSERT_NXT(a_gap_after_last, i_clk, i_rst_n, o_valid && o_last_digit, !o_valid, "digit follows last digit at once")
    `RDC_ASSERT_IMP(a_digit_range, i_clk, i_rst_n, o_valid, o_digit <= DIGIT_W'(9), "digit out of range")
    `RDC_ASSERT_NXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy, "busy not raised after transaction")

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_digit      (o_digit),
    .o_last_digit (o_last_digit)
);
